// File: hw/rtl/dtq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dtq_pkg - drop-tail queue shared definitions
// Widths, reset values, function codes and parameter defaults.
// ============================================================================
package dtq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 64;
    localparam int HANDLE_BITS_DEFAULT = 32;

    localparam int ID_W    = 32;   // packet_id / sent_packet port width
    localparam int LEN_W   = 7;    // queue_length and capacity width
    localparam int CNT_W   = 32;   // statistics counters
    localparam int RATIO_W = 16;   // 0.16 drop ratio

    localparam int DIVIDEND_W = CNT_W + RATIO_W;
    localparam int DIVISOR_W  = CNT_W;

    localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [1:0] {
        FUNC_ARRIVE  = 2'd0,
        FUNC_REQUEST = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_STATS   = 2'd3
    } func_t;

    localparam logic ADDR_CAPACITY = 1'b0;

endpackage

// File: hw/rtl/dtq_store.sv
`timescale 1ns / 1ps
// ============================================================================
// dtq_store - handle storage
// One write port, one read port, registered read data.
// ============================================================================
module dtq_store
    import dtq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
    parameter int WIDTH = HANDLE_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dtq_div.sv
`timescale 1ns / 1ps
// ============================================================================
// dtq_div - serial restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ============================================================================
module dtq_div
    import dtq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] dq_reg, dq_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    assign shifted = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (run_reg)
        begin
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            if (step_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// File: hw/rtl/drop_tail_packet_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// drop_tail_packet_queue - output-port drop-tail queue with idle-link bypass
// Arrivals bypass to an idle link, queue below capacity, or drop and count.
// Requests pop the head; clear empties the queue; a statistics read returns
// the window drop ratio through a serial divider.
// ============================================================================
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------
//  command   start & !busy accepts      func, packet_id
//  result    done, one cycle            sent, sent_packet, dropped,
//                                       queue_length, total_dropped, drop_ratio
//  config    APB write, psel&penable    paddr, pwdata -> queue_capacity
//
//  Arrival, request and clear items pass from accept (registered store read)
//  through S_EXEC, which updates the queue and registers the done strobe.
//  A statistics read with arrivals seen waits in S_DIV for the serial divider
//  (48 iterations for the 48-bit dividend); without arrivals it ends in S_EXEC.
//  busy is high from accept until done; start is ignored meanwhile.
//  The receiver cannot stall: done is shown for one cycle only.
//  Reset (rst_n low, async) empties the queue, marks the link idle, zeroes the
//  counters and sets queue_capacity to 64. Store contents are not cleared.
// ============================================================================
module drop_tail_packet_queue
    import dtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
    parameter int HANDLE_BITS = HANDLE_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    // command
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [ID_W-1:0]    packet_id,
    // result
    output logic               done,
    output logic               sent,
    output logic [ID_W-1:0]    sent_packet,
    output logic               dropped,
    output logic [LEN_W-1:0]   queue_length,
    output logic [CNT_W-1:0]   total_dropped,
    output logic [RATIO_W-1:0] drop_ratio,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    // handle bits kept from the 32-bit port
    localparam int KEEP  = (HANDLE_BITS < ID_W) ? HANDLE_BITS : ID_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [DIVIDEND_W-1:0] RATIO_MAX = DIVIDEND_W'({RATIO_W{1'b1}});

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // ---------------------------------------------------------------- state
    state_t                 state_reg, state_next;
    func_t                  func_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    logic [LEN_W-1:0] cap_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [LEN_W-1:0] held_reg, held_next;
    logic             link_idle_reg, link_idle_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] arr_reg, arr_next;
    logic [CNT_W-1:0] wdrop_reg, wdrop_next;

    // registered result
    logic               done_reg, done_next;
    logic               sent_reg, sent_next;
    logic [ID_W-1:0]    pkt_reg, pkt_next;
    logic               dropped_reg, dropped_next;
    logic [LEN_W-1:0]   qlen_reg, qlen_next;
    logic [CNT_W-1:0]   tot_out_reg, tot_out_next;
    logic [RATIO_W-1:0] ratio_reg, ratio_next;

    // store and divider hookup
    logic                   st_we;
    logic [IDX_W-1:0]       st_waddr;
    logic [HANDLE_BITS-1:0] st_rdata;
    logic                   div_start;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  div_q;

    logic [LEN_W-1:0] cap_eff;
    logic [31:0]      slot_sum;
    logic             accept;
    logic             cfg_write;

    assign accept    = start && (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite;

    // capacity beyond the store depth behaves as the depth
    assign cap_eff  = (32'(cap_reg) > 32'(QUEUE_DEPTH)) ? LEN_W'(QUEUE_DEPTH) : cap_reg;
    // tail slot; head + held stays below twice the depth
    assign slot_sum = 32'(head_reg) + 32'(held_reg);
    assign st_waddr = (slot_sum >= 32'(QUEUE_DEPTH)) ? IDX_W'(slot_sum - 32'(QUEUE_DEPTH))
                                                     : IDX_W'(slot_sum);

    dtq_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (HANDLE_BITS)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (handle_reg),
        .raddr (head_reg),
        .rdata (st_rdata)
    );

    dtq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({wdrop_reg, {RATIO_W{1'b0}}}),
        .divisor  (arr_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        held_next      = held_reg;
        link_idle_next = link_idle_reg;
        total_next     = total_reg;
        arr_next       = arr_reg;
        wdrop_next     = wdrop_reg;
        st_we          = 1'b0;
        div_start      = 1'b0;

        done_next    = 1'b0;
        sent_next    = sent_reg;
        pkt_next     = pkt_reg;
        dropped_next = dropped_reg;
        qlen_next    = qlen_reg;
        tot_out_next = tot_out_reg;
        ratio_next   = ratio_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                sent_next    = 1'b0;
                pkt_next     = '0;
                dropped_next = 1'b0;
                ratio_next   = '0;
                done_next    = 1'b1;
                state_next   = S_IDLE;
                case (func_reg)
                    FUNC_ARRIVE:
                    begin
                        arr_next = sat_inc(arr_reg);
                        if (link_idle_reg)
                        begin
                            link_idle_next = 1'b0;
                            sent_next      = 1'b1;
                            pkt_next       = ID_W'(handle_reg[KEEP-1:0]);
                        end
                        else if (held_reg < cap_eff)
                        begin
                            st_we     = 1'b1;
                            held_next = held_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                            wdrop_next   = sat_inc(wdrop_reg);
                            total_next   = sat_inc(total_reg);
                        end
                    end
                    FUNC_REQUEST:
                    begin
                        if (held_reg != '0)
                        begin
                            sent_next = 1'b1;
                            pkt_next  = ID_W'(st_rdata[KEEP-1:0]);
                            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                            held_next = held_reg - 1'b1;
                        end
                        else
                        begin
                            link_idle_next = 1'b1;
                        end
                    end
                    FUNC_CLEAR:
                    begin
                        held_next  = '0;
                        total_next = '0;
                    end
                    default:
                    begin
                        // statistics read: divider latches operands now
                        arr_next   = '0;
                        wdrop_next = '0;
                        if (arr_reg != '0)
                        begin
                            div_start  = 1'b1;
                            done_next  = 1'b0;
                            state_next = S_DIV;
                        end
                    end
                endcase
                qlen_next    = held_next;
                tot_out_next = total_next;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    ratio_next = (div_q > RATIO_MAX) ? {RATIO_W{1'b1}}
                                                     : div_q[RATIO_W-1:0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            head_reg      <= '0;
            held_reg      <= '0;
            link_idle_reg <= 1'b1;
            total_reg     <= '0;
            arr_reg       <= '0;
            wdrop_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            link_idle_reg <= link_idle_next;
            total_reg     <= total_next;
            arr_reg       <= arr_next;
            wdrop_reg     <= wdrop_next;
            done_reg      <= done_next;
            if (cfg_write && (paddr[2] == ADDR_CAPACITY))
            begin
                cap_reg <= pwdata[LEN_W-1:0];
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func_t'(func);
            handle_reg <= HANDLE_BITS'(packet_id[KEEP-1:0]);
        end
        sent_reg    <= sent_next;
        pkt_reg     <= pkt_next;
        dropped_reg <= dropped_next;
        qlen_reg    <= qlen_next;
        tot_out_reg <= tot_out_next;
        ratio_reg   <= ratio_next;
    end

    // ---------------------------------------------------------------- ports
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign sent          = sent_reg;
    assign sent_packet   = pkt_reg;
    assign dropped       = dropped_reg;
    assign queue_length  = qlen_reg;
    assign total_dropped = tot_out_reg;
    assign drop_ratio    = ratio_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_CAPACITY) ? 32'(cap_reg) : '0;

endmodule

// File: test/drop_tail_packet_queue_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// drop_tail_packet_queue_tb - self-checking bench for the drop-tail queue
// Drives arrival, request, clear and statistics items through the command
// port and sets queue_capacity over APB between phases. Every accepted item
// is run through a cycle-free queue predictor. Each done strobe is checked
// field by field against the oldest predicted outcome.
// ============================================================================
module drop_tail_packet_queue_tb;
    import dtq_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int          CLK_HALF     = 6;      // 12 ns period
    localparam int          RESET_CYCLES = 5;
    localparam int          DEPTH        = QUEUE_DEPTH_DEFAULT;
    // Slowest legal quiet stretch is a statistics divide plus the longest
    // sender gap; the limit is taken well above that.
    localparam int          STALL_LIMIT  = 1000;
    // Settling time after the last result: one full statistics read.
    localparam int          TAIL_CYCLES  = 60;
    localparam int          N_PHASES     = 12;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          SHOW_LIMIT   = 10;
    localparam logic [2:0]  CAPACITY_ADDR = {ADDR_CAPACITY, 2'b00};

    typedef struct packed {
        func_t              op;
        logic [ID_W-1:0]    id;
    } cmd_t;

    typedef struct packed {
        logic               sent;
        logic [ID_W-1:0]    sent_packet;
        logic               dropped;
        logic [LEN_W-1:0]   queue_length;
        logic [CNT_W-1:0]   total_dropped;
        logic [RATIO_W-1:0] drop_ratio;
    } outcome_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic [1:0]         func      = FUNC_ARRIVE;
    logic [ID_W-1:0]    packet_id = '0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [2:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;

    logic               busy;
    logic               done;
    logic               sent;
    logic [ID_W-1:0]    sent_packet;
    logic               dropped;
    logic [LEN_W-1:0]   queue_length;
    logic [CNT_W-1:0]   total_dropped;
    logic [RATIO_W-1:0] drop_ratio;
    logic [31:0]        prdata;
    logic               pready;

    drop_tail_packet_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .packet_id     (packet_id),
        .done          (done),
        .sent          (sent),
        .sent_packet   (sent_packet),
        .dropped       (dropped),
        .queue_length  (queue_length),
        .total_dropped (total_dropped),
        .drop_ratio    (drop_ratio),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Queue predictor state: its own copy of the store, pointers, link flag,
    // counters and capacity setting.
    // ------------------------------------------------------------------------
    logic [ID_W-1:0]    q_store [DEPTH];
    logic [5:0]         q_head;
    logic [LEN_W-1:0]   q_held;
    logic               q_link_idle;
    logic [CNT_W-1:0]   q_drops_total;
    logic [CNT_W-1:0]   q_win_arrivals;
    logic [CNT_W-1:0]   q_win_drops;
    logic [LEN_W-1:0]   q_capacity;

    // Coverage tallies for the closing summary
    int unsigned        n_arrivals, n_bypassed, n_dropped, n_requests;
    int unsigned        n_clears, n_stats, n_settings;

    // Bench bookkeeping
    cmd_t               pending_cmds [$];   // items waiting to be driven
    outcome_t           outcomes_due [$];   // predicted results, oldest first
    int unsigned        n_pushed   = 0;
    int unsigned        n_accepted = 0;
    int unsigned        mismatches = 0;
    int unsigned        strays     = 0;
    int unsigned        stall_cycles = 0;
    int unsigned        gap_pct    = 0;     // sender idle chance per item, %
    int unsigned        gap_left   = 0;
    cmd_t               drv_item;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // One item through the queue: updates predictor state, returns the result.
    task automatic queue_model_step(input cmd_t c, output outcome_t r);
        logic [LEN_W-1:0]   cap;
        logic [47:0]        quotient;
        cap = (q_capacity > LEN_W'(DEPTH)) ? LEN_W'(DEPTH) : q_capacity;
        r = '0;
        case (c.op)
            FUNC_ARRIVE:
            begin
                n_arrivals++;
                q_win_arrivals = sat_inc(q_win_arrivals);
                if (q_link_idle)
                begin
                    // idle link: bypass straight out, link now busy
                    q_link_idle   = 1'b0;
                    r.sent        = 1'b1;
                    r.sent_packet = c.id;
                    n_bypassed++;
                end
                else if (q_held < cap)
                begin
                    q_store[q_head + q_held[5:0]] = c.id;
                    q_held = q_held + 1'b1;
                end
                else
                begin
                    r.dropped     = 1'b1;
                    q_win_drops   = sat_inc(q_win_drops);
                    q_drops_total = sat_inc(q_drops_total);
                    n_dropped++;
                end
            end
            FUNC_REQUEST:
            begin
                n_requests++;
                if (q_held != '0)
                begin
                    r.sent        = 1'b1;
                    r.sent_packet = q_store[q_head];
                    q_head        = q_head + 1'b1;
                    q_held        = q_held - 1'b1;
                end
                else
                begin
                    q_link_idle = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                // link flag and window counters survive a clear
                n_clears++;
                q_held        = '0;
                q_drops_total = '0;
            end
            default:
            begin
                n_stats++;
                if (q_win_arrivals != '0)
                begin
                    quotient     = {q_win_drops, 16'h0000} / {16'h0000, q_win_arrivals};
                    r.drop_ratio = (quotient > 48'd65535) ? 16'hFFFF : quotient[15:0];
                end
                q_win_drops    = '0;
                q_win_arrivals = '0;
            end
        endcase
        r.queue_length  = q_held;
        r.total_dropped = q_drops_total;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents pending items, holds start until accepted, predicts
    // at acceptance, and inserts random idle bursts between items.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            func      <= FUNC_ARRIVE;
            packet_id <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                outcome_t predicted;
                queue_model_step(drv_item, predicted);
                outcomes_due.push_back(predicted);
                n_accepted++;
                if (gap_pct != 0 && $urandom_range(99, 0) < gap_pct)
                    gap_left = $urandom_range(11, 1);
            end
            // free to present a new item once the current one is taken
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    drv_item   = pending_cmds.pop_front();
                    start     <= 1'b1;
                    func      <= drv_item.op;
                    packet_id <= drv_item.id;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every done strobe is matched against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                strays++;
                if (mismatches + strays <= SHOW_LIMIT)
                    $display("[%0t] result with no item outstanding: sent=%0b pkt=%h",
                             $realtime, sent, sent_packet);
            end
            else
            begin
                outcome_t want;
                want = outcomes_due.pop_front();
                if (sent !== want.sent || sent_packet !== want.sent_packet ||
                    dropped !== want.dropped || queue_length !== want.queue_length ||
                    total_dropped !== want.total_dropped ||
                    drop_ratio !== want.drop_ratio)
                begin
                    mismatches++;
                    if (mismatches + strays <= SHOW_LIMIT)
                    begin
                        $display("[%0t] exp: s=%0b pkt=%h d=%0b len=%0d tot=%0d ratio=%0d",
                                 $realtime, want.sent, want.sent_packet, want.dropped,
                                 want.queue_length, want.total_dropped, want.drop_ratio);
                        $display("[%0t] act: s=%0b pkt=%h d=%0b len=%0d tot=%0d ratio=%0d",
                                 $realtime, sent, sent_packet, dropped,
                                 queue_length, total_dropped, drop_ratio);
                    end
                end
            end
        end
    end

    // Cycles with nothing accepted on any port
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (rst_n);
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("[%0t] watchdog: no traffic for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAIL drop_tail_packet_queue");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_cmd(input func_t op, input logic [ID_W-1:0] id);
        cmd_t c;
        c.op = op;
        c.id = id;
        pending_cmds.push_back(c);
        n_pushed++;
    endtask

    function automatic logic [ID_W-1:0] random_handle();
        if ($urandom_range(15, 0) == 0)
            return $urandom_range(1, 0) ? '1 : '0;
        return $urandom;
    endfunction

    // Block until every pushed item has been accepted and answered.
    task automatic wait_drained();
        while (n_accepted != n_pushed || outcomes_due.size() != 0)
            @(posedge clk);
    endtask

    // APB write of queue_capacity; only called with the block idle.
    task automatic write_capacity(input logic [LEN_W-1:0] cap);
        q_capacity = cap;
        n_settings++;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= 32'(cap);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly runs of arrivals that fill the queue and runs of requests that
    // drain it, mixed with single random items, clears and statistics reads.
    // Runs are trimmed so a phase ends at its item budget.
    task automatic queue_random_phase(input int n_items, input int arrive_pct);
        int made;
        int run;
        int pick;
        made = 0;
        while (made < n_items)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 12)
            begin
                run = $urandom_range(70, 4);
                if (run > n_items - made)
                    run = n_items - made;
                repeat (run) push_cmd(FUNC_ARRIVE, random_handle());
                made += run;
            end
            else if (pick < 20)
            begin
                run = $urandom_range(70, 4);
                if (run > n_items - made)
                    run = n_items - made;
                repeat (run) push_cmd(FUNC_REQUEST, random_handle());
                made += run;
            end
            else
            begin
                if (pick < 23)
                    push_cmd(FUNC_CLEAR, random_handle());
                else if (pick < 27)
                    push_cmd(FUNC_STATS, random_handle());
                else if ($urandom_range(99, 0) < arrive_pct)
                    push_cmd(FUNC_ARRIVE, random_handle());
                else
                    push_cmd(FUNC_REQUEST, random_handle());
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    logic [LEN_W-1:0] cap_plan [N_PHASES];

    initial
    begin
        // predictor reset image
        q_head         = '0;
        q_held         = '0;
        q_link_idle    = 1'b1;
        q_drops_total  = '0;
        q_win_arrivals = '0;
        q_win_drops    = '0;
        q_capacity     = CAP_RESET;
        n_arrivals = 0; n_bypassed = 0; n_dropped = 0; n_requests = 0;
        n_clears   = 0; n_stats    = 0; n_settings = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, reset capacity -------------------------------------
        push_cmd(FUNC_REQUEST, 32'h0000_0000);   // empty queue, link stays idle
        push_cmd(FUNC_STATS,   32'hFFFF_FFFF);   // no arrivals: ratio zero
        push_cmd(FUNC_ARRIVE,  32'h0000_0000);   // bypass on idle link
        push_cmd(FUNC_ARRIVE,  32'hFFFF_FFFF);   // queued behind busy link
        push_cmd(FUNC_ARRIVE,  32'hAAAA_AAAA);
        push_cmd(FUNC_ARRIVE,  32'h5555_5555);
        push_cmd(FUNC_REQUEST, 32'h0000_0000);   // pops the all-ones handle
        push_cmd(FUNC_CLEAR,   32'h0000_0000);   // empties, link stays busy
        push_cmd(FUNC_ARRIVE,  32'h1234_5678);   // queued, no bypass after clear
        push_cmd(FUNC_REQUEST, 32'h0000_0000);
        push_cmd(FUNC_REQUEST, 32'h0000_0000);   // empty: link goes idle
        push_cmd(FUNC_STATS,   32'h0000_0000);
        wait_drained();

        // ---- directed, zero capacity --------------------------------------
        write_capacity(7'd0);
        push_cmd(FUNC_ARRIVE,  32'h0000_0001);   // bypass still allowed
        push_cmd(FUNC_ARRIVE,  32'h0000_0002);   // busy link, nothing fits
        push_cmd(FUNC_ARRIVE,  32'h0000_0003);
        push_cmd(FUNC_STATS,   32'h0000_0000);   // two of three dropped
        push_cmd(FUNC_ARRIVE,  32'hFFFF_FFFF);
        push_cmd(FUNC_ARRIVE,  32'h0000_0000);
        push_cmd(FUNC_STATS,   32'h0000_0000);   // all dropped: full-scale ratio
        push_cmd(FUNC_CLEAR,   32'h0000_0000);   // total drop count back to zero
        push_cmd(FUNC_REQUEST, 32'h0000_0000);
        push_cmd(FUNC_STATS,   32'h0000_0000);
        wait_drained();

        // ---- random phases over several capacity settings -----------------
        cap_plan = '{7'd127, 7'd0, 7'd1, 7'd64, 7'd65, 7'd96, 7'd2,
                     7'($urandom_range(63, 3)), 7'($urandom_range(63, 3)),
                     7'($urandom_range(127, 3)), 7'd63, 7'd64};
        for (int p = 0; p < N_PHASES; p++)
        begin
            // some phases run back to back; the last one never idles
            if (p == 3 || p == 6 || p == N_PHASES - 1)
                gap_pct = 0;
            else
                gap_pct = $urandom_range(40, 10);
            write_capacity(cap_plan[p]);
            queue_random_phase(PHASE_ITEMS, $urandom_range(75, 35));
            // sender holds off here until every outstanding result is in
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d items, %0d cap settings, %0d arrivals (%0d bypass, %0d drop)",
                 n_accepted, n_settings, n_arrivals, n_bypassed, n_dropped);
        $display("  %0d requests, %0d clears, %0d stats reads; %0d mismatches, %0d strays",
                 n_requests, n_clears, n_stats, mismatches, strays);
        if (mismatches == 0 && strays == 0 && outcomes_due.size() == 0)
        begin
            $display("PASS drop_tail_packet_queue");
        end
        else
        begin
            $display("FAIL drop_tail_packet_queue");
        end
        $finish;
    end

endmodule
